>>> rtl/tms_pkg.sv
// Shared constants, types, note ROM and microcode ROM of the tone melody sequencer.
package tms_pkg;

    localparam int NOTE_SLOTS = 8;
    localparam int IDX_W      = $clog2(NOTE_SLOTS + 2);

    localparam int BASE_W = 24;
    localparam int TONE_W = 16;
    localparam int LEN_W  = 16;
    localparam int TIME_W = 32;
    localparam int FUNC_W = 3;
    localparam int ID_W   = 2;
    localparam int DIVR_W = 16;

    localparam logic [BASE_W-1:0] BASE_CLOCK_RESET = 24'd1193180;

    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_TONE   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TIMED  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_MELODY = 3'd4;

    localparam int ROM_NOTES = 8;
    localparam int ROM_AW    = $clog2(ROM_NOTES);

    // microcode step addresses
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] S_DISPATCH = 4'd0;
    localparam logic [PC_W-1:0] S_TICK     = 4'd1;
    localparam logic [PC_W-1:0] S_ADVANCE  = 4'd2;
    localparam logic [PC_W-1:0] S_LOAD     = 4'd3;
    localparam logic [PC_W-1:0] S_SET_END  = 4'd4;
    localparam logic [PC_W-1:0] S_TONE     = 4'd5;
    localparam logic [PC_W-1:0] S_DIV_WAIT = 4'd6;
    localparam logic [PC_W-1:0] S_DIV_DONE = 4'd7;
    localparam logic [PC_W-1:0] S_OFF      = 4'd8;
    localparam logic [PC_W-1:0] S_EMIT     = 4'd9;
    localparam logic [PC_W-1:0] S_TIMED    = 4'd10;
    localparam logic [PC_W-1:0] S_MEL_INIT = 4'd11;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_DISPATCH,
        C_TICK_SKIP,
        C_NO_NEXT,
        C_HZ_ZERO,
        C_DIV_BUSY,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        logic take;
        logic off;
        logic idx_inc;
        logic load_rom;
        logic set_end;
        logic clr_queue;
        logic mel_init;
        logic div_start;
        logic div_finish;
        logic emit;
    } t_act;

    typedef struct packed {
        t_cond             cond;
        logic [PC_W-1:0]   target;
        t_act              act;
    } t_uword;

    typedef struct packed {
        logic              accept;
        logic [FUNC_W-1:0] func;
        logic              tick_skip;
        logic              no_next;
        logic              hz_zero;
        logic              div_busy;
        logic              out_free;
    } t_seq_flags;

    function automatic logic [TONE_W-1:0] rom_tone(input logic [ROM_AW-1:0] a);
        logic [TONE_W-1:0] t;
        case (a)
            3'd0:    t = 16'd523;
            3'd1:    t = 16'd659;
            3'd2:    t = 16'd784;
            3'd3:    t = 16'd1047;
            3'd4:    t = 16'd220;
            3'd5:    t = 16'd880;
            3'd6:    t = 16'd1175;
            default: t = 16'd1318;
        endcase
        return t;
    endfunction

    function automatic logic [LEN_W-1:0] rom_len(input logic [ROM_AW-1:0] a);
        logic [LEN_W-1:0] l;
        case (a)
            3'd0:    l = 16'd120;
            3'd1:    l = 16'd120;
            3'd2:    l = 16'd120;
            3'd3:    l = 16'd200;
            3'd4:    l = 16'd300;
            3'd5:    l = 16'd60;
            3'd6:    l = 16'd80;
            default: l = 16'd100;
        endcase
        return l;
    endfunction

    function automatic logic [ROM_AW-1:0] preset_start(input logic [ID_W-1:0] id);
        logic [ROM_AW-1:0] s;
        case (id)
            2'd0:    s = 3'd0;
            2'd1:    s = 3'd4;
            2'd2:    s = 3'd5;
            default: s = 3'd7;
        endcase
        return s;
    endfunction

    function automatic int preset_notes(input logic [ID_W-1:0] id);
        int n;
        case (id)
            2'd0:    n = 4;
            2'd1:    n = 1;
            2'd2:    n = 2;
            default: n = 1;
        endcase
        return n;
    endfunction

    // melody length clipped to the queue size
    function automatic logic [IDX_W-1:0] preset_count(input logic [ID_W-1:0] id);
        int n;
        n = preset_notes(id);
        if (n > NOTE_SLOTS) begin
            n = NOTE_SLOTS;
        end
        return IDX_W'(n);
    endfunction

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        w.cond   = C_NEXT;
        w.target = S_DISPATCH;
        case (pc)
            S_DISPATCH: begin
                w.cond     = C_DISPATCH;
                w.act.take = 1'b1;
            end
            S_TICK: begin
                w.cond   = C_TICK_SKIP;
                w.target = S_EMIT;
            end
            S_ADVANCE: begin
                w.cond        = C_NO_NEXT;
                w.target      = S_EMIT;
                w.act.off     = 1'b1;
                w.act.idx_inc = 1'b1;
            end
            S_LOAD: begin
                w.act.load_rom = 1'b1;
            end
            S_SET_END: begin
                w.cond        = C_JUMP;
                w.target      = S_TONE;
                w.act.set_end = 1'b1;
            end
            S_TONE: begin
                w.cond          = C_HZ_ZERO;
                w.target        = S_OFF;
                w.act.div_start = 1'b1;
            end
            S_DIV_WAIT: begin
                w.cond   = C_DIV_BUSY;
                w.target = S_DIV_WAIT;
            end
            S_DIV_DONE: begin
                w.cond           = C_JUMP;
                w.target         = S_EMIT;
                w.act.div_finish = 1'b1;
            end
            S_OFF: begin
                w.cond    = C_JUMP;
                w.target  = S_EMIT;
                w.act.off = 1'b1;
            end
            S_EMIT: begin
                w.cond     = C_OUT_FREE;
                w.target   = S_DISPATCH;
                w.act.emit = 1'b1;
            end
            S_TIMED: begin
                w.cond          = C_JUMP;
                w.target        = S_TONE;
                w.act.clr_queue = 1'b1;
                w.act.set_end   = 1'b1;
            end
            S_MEL_INIT: begin
                w.cond         = C_JUMP;
                w.target       = S_LOAD;
                w.act.mel_init = 1'b1;
            end
            default: begin
                w.cond   = C_JUMP;
                w.target = S_DISPATCH;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/tms_div.sv
// Restoring divider, one quotient bit per cycle: base clock over tone frequency.
module tms_div
    import tms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [BASE_W-1:0] i_dividend,
    input  logic [TONE_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [BASE_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(BASE_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic [BASE_W-1:0] r_quo;
    logic [TONE_W-1:0] r_rem;
    logic [TONE_W-1:0] r_den;
    logic [TONE_W:0]   rem_sh;
    logic              fits;

    assign rem_sh = {r_rem, r_quo[BASE_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(BASE_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            // shift in the next dividend bit, subtract where it fits
            if (fits) begin
                r_rem <= TONE_W'(rem_sh - {1'b0, r_den});
                r_quo <= {r_quo[BASE_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[TONE_W-1:0];
                r_quo <= {r_quo[BASE_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;

endmodule

>>> rtl/tms_useq.sv
// Microcode sequencer: step counter, control word ROM and conditional jumps.
module tms_useq
    import tms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_seq_flags i_flags,
    output t_uword     o_uword
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic [PC_W-1:0] entry;
    t_uword          uw;

    assign uw      = ucode(r_pc);
    assign o_uword = uw;

    always_comb begin
        case (i_flags.func)
            FUNC_TICK:   entry = S_TICK;
            FUNC_TONE:   entry = S_TONE;
            FUNC_STOP:   entry = S_OFF;
            FUNC_TIMED:  entry = S_TIMED;
            FUNC_MELODY: entry = S_MEL_INIT;
            default:     entry = S_EMIT;
        endcase
    end

    always_comb begin
        n_pc = r_pc + 1'b1;
        case (uw.cond)
            C_NEXT:      n_pc = r_pc + 1'b1;
            C_JUMP:      n_pc = uw.target;
            C_DISPATCH:  n_pc = i_flags.accept ? entry : r_pc;
            C_TICK_SKIP: n_pc = i_flags.tick_skip ? uw.target : r_pc + 1'b1;
            C_NO_NEXT:   n_pc = i_flags.no_next ? uw.target : r_pc + 1'b1;
            C_HZ_ZERO:   n_pc = i_flags.hz_zero ? uw.target : r_pc + 1'b1;
            C_DIV_BUSY:  n_pc = i_flags.div_busy ? uw.target : r_pc + 1'b1;
            C_OUT_FREE:  n_pc = i_flags.out_free ? uw.target : r_pc;
            default:     n_pc = S_DISPATCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_DISPATCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> rtl/tone_melody_sequencer.sv
// Tone melody sequencer top level: command datapath around the microcode sequencer.
//
// One command is taken at a time and gives one result. An unused code goes straight to
// the emit step; a stop passes the off step first, and a tick that ends nothing passes
// only the tick check. A tick that ends the last note passes the tick check and the
// advance step. A continuous tone of 0 Hz passes the tone and off steps; a timed tone
// of 0 Hz first clears the queue and sets its end time. A command that programs a
// divisor starts the shared restoring divider, waits through its 24 one-bit steps until
// it is idle, then loads the divisor; a melody start first loads its first note from the
// ROM, and a tick that moves to the next note loads that note. After the result is
// registered the sequencer returns to dispatch for the next command, which is taken while
// the finished result sits in the output register; a new result waits until that one is
// taken. The base clock register may be written at any time the block is idle.
module tone_melody_sequencer
    import tms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BASE_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [TONE_W-1:0] i_tone_hz,
    input  logic [LEN_W-1:0]  i_length_ms,
    input  logic [ID_W-1:0]   i_preset_id,
    input  logic [TIME_W-1:0] i_now,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_speaker_on,
    output logic [DIVR_W-1:0] o_divisor,
    output logic              o_divisor_loaded,
    output logic              o_busy_res
);

    t_uword     uw;
    t_seq_flags flags;

    logic              accept;
    logic              div_busy;
    logic [BASE_W-1:0] quotient;
    logic [ROM_AW-1:0] rom_addr;
    logic [IDX_W-1:0]  idx_step;

    logic [BASE_W-1:0] r_base;
    logic [TONE_W-1:0] r_hz;
    logic [LEN_W-1:0]  r_len;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_now;
    logic [ROM_AW-1:0] r_start;
    logic [IDX_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_idx;
    logic [TIME_W-1:0] r_end;
    logic              r_sounding;
    logic [DIVR_W-1:0] r_divisor;
    logic              r_loaded;

    logic              r_out_valid;
    logic              r_out_speaker;
    logic [DIVR_W-1:0] r_out_divisor;
    logic              r_out_loaded;
    logic              r_out_busy;

    assign o_stall = !uw.act.take;
    assign accept  = i_valid && uw.act.take;

    // melody notes are read straight from the ROM window that the preset selects
    assign rom_addr = r_start + ROM_AW'(r_idx);

    // advance the note index, saturating at NOTE_SLOTS + 1, two past the last slot
    assign idx_step = (r_idx < IDX_W'(NOTE_SLOTS + 1)) ? r_idx + 1'b1 : r_idx;

    assign flags.accept    = accept;
    assign flags.func      = i_func;
    assign flags.tick_skip = (!r_sounding && (r_idx >= r_cnt)) || (r_now < r_end);
    assign flags.no_next   = (idx_step >= r_cnt) || (idx_step >= IDX_W'(NOTE_SLOTS));
    assign flags.hz_zero   = r_hz == '0;
    assign flags.div_busy  = div_busy;
    assign flags.out_free  = !r_out_valid || !i_stall;

    tms_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw)
    );

    tms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (uw.act.div_start),
        .i_dividend (r_base),
        .i_divisor  (r_hz),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_CLOCK_RESET;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_data;
        end
    end

    // command operands
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hz  <= i_tone_hz;
            r_len <= i_length_ms;
            r_id  <= i_preset_id;
            r_now <= i_now;
        end else if (uw.act.load_rom) begin
            r_hz  <= rom_tone(rom_addr);
            r_len <= rom_len(rom_addr);
        end
        if (uw.act.mel_init) begin
            r_start <= preset_start(r_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_idx      <= '0;
            r_end      <= '0;
            r_sounding <= 1'b0;
            r_divisor  <= '0;
            r_loaded   <= 1'b0;
        end else begin
            if (accept) begin
                r_loaded <= 1'b0;
            end
            if (uw.act.off) begin
                r_sounding <= 1'b0;
            end
            if (uw.act.idx_inc) begin
                r_idx <= idx_step;
            end
            if (uw.act.clr_queue) begin
                r_cnt <= '0;
                r_idx <= '0;
            end
            if (uw.act.mel_init) begin
                r_cnt <= preset_count(r_id);
                r_idx <= '0;
            end
            if (uw.act.set_end) begin
                r_end <= r_now + TIME_W'(r_len);
            end
            if (uw.act.div_finish) begin
                // floor a zero quotient at one
                r_divisor  <= (quotient == '0) ? DIVR_W'(1) : quotient[DIVR_W-1:0];
                r_loaded   <= 1'b1;
                r_sounding <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.act.emit && flags.out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.act.emit && flags.out_free) begin
            r_out_speaker <= r_sounding;
            r_out_divisor <= r_divisor;
            r_out_loaded  <= r_loaded;
            r_out_busy    <= r_sounding || (r_idx < r_cnt);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_speaker_on     = r_out_speaker;
    assign o_divisor        = r_out_divisor;
    assign o_divisor_loaded = r_out_loaded;
    assign o_busy_res       = r_out_busy;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the tone melody sequencer: directed table, random scenarios, predictor.
module testbench;
    import tms_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int ITEMS        = 850;
    localparam int PHASES       = 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 4000;
    localparam int REPORT_MAX   = 10;
    localparam int DIR_ROWS     = 25;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_MID   = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

    localparam logic [ID_W-1:0] PRESET_BOOT   = 2'd0;
    localparam logic [ID_W-1:0] PRESET_ERROR  = 2'd1;
    localparam logic [ID_W-1:0] PRESET_WINDOW = 2'd2;
    localparam logic [ID_W-1:0] PRESET_NOTIFY = 2'd3;

    typedef struct packed {
        logic              spk;
        logic [DIVR_W-1:0] div;
        logic              loaded;
        logic              busy;
    } tone_result_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TONE_W-1:0] hz;
        logic [LEN_W-1:0]  len;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        logic              fixed;
        tone_result_t      want;
    } dir_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [BASE_W-1:0] i_cfg_data;
    logic              i_valid;
    logic              o_stall;
    logic [FUNC_W-1:0] i_func;
    logic [TONE_W-1:0] i_tone_hz;
    logic [LEN_W-1:0]  i_length_ms;
    logic [ID_W-1:0]   i_preset_id;
    logic [TIME_W-1:0] i_now;
    logic              o_valid;
    logic              i_stall;
    logic              o_speaker_on;
    logic [DIVR_W-1:0] o_divisor;
    logic              o_divisor_loaded;
    logic              o_busy_res;

    // predictor state
    logic [BASE_W-1:0] base_hz;
    logic [31:0]       note_q [NOTE_SLOTS];
    int                note_cnt;
    int                note_pos;
    logic [TIME_W-1:0] end_ms;
    logic              spk_on;
    logic [DIVR_W-1:0] div_q;
    logic              div_fresh;

    tone_result_t      tone_expect_q [$];
    tone_result_t      head_r;
    int                mismatches;
    int                moved_items;
    int                quiet_cycles;
    int                rx_left;
    bit                tx_calm;
    bit                rx_calm;
    logic [TIME_W-1:0] ms_clock;

    tone_melody_sequencer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_tone_hz        (i_tone_hz),
        .i_length_ms      (i_length_ms),
        .i_preset_id      (i_preset_id),
        .i_now            (i_now),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_speaker_on     (o_speaker_on),
        .o_divisor        (o_divisor),
        .o_divisor_loaded (o_divisor_loaded),
        .o_busy_res       (o_busy_res)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #CLK_HALF i_clk = ~i_clk;

    // melody ROM: tone in the high half, duration in the low half
    function automatic logic [31:0] chime_note(input int a);
        case (a)
            0:       return {16'd523, 16'd120};
            1:       return {16'd659, 16'd120};
            2:       return {16'd784, 16'd120};
            3:       return {16'd1047, 16'd200};
            4:       return {16'd220, 16'd300};
            5:       return {16'd880, 16'd60};
            6:       return {16'd1175, 16'd80};
            default: return {16'd1318, 16'd100};
        endcase
    endfunction

    function automatic void chime_span(input logic [ID_W-1:0] id, output int first,
                                       output int cnt);
        case (id)
            PRESET_BOOT: begin
                first = 0;
                cnt   = 4;
            end
            PRESET_ERROR: begin
                first = 4;
                cnt   = 1;
            end
            PRESET_WINDOW: begin
                first = 5;
                cnt   = 2;
            end
            default: begin
                first = 7;
                cnt   = 1;
            end
        endcase
    endfunction

    function automatic void tone_on(input logic [TONE_W-1:0] hz);
        logic [31:0] q;
        if (hz == '0) begin
            spk_on = 1'b0;
        end else begin
            q = 32'(base_hz) / 32'(hz);
            if (q == 0) begin
                q = 1;
            end
            div_q     = q[DIVR_W-1:0];
            div_fresh = 1'b1;
            spk_on    = 1'b1;
        end
    endfunction

    function automatic tone_result_t tone_predict(input logic [FUNC_W-1:0] f,
                                                  input logic [TONE_W-1:0] hz,
                                                  input logic [LEN_W-1:0]  len,
                                                  input logic [ID_W-1:0]   id,
                                                  input logic [TIME_W-1:0] now);
        logic [31:0]  e;
        int           first;
        int           cnt;
        tone_result_t r;
        div_fresh = 1'b0;
        case (f)
            FUNC_TICK: begin
                // end the note once its time is up, then step to the next one
                if ((spk_on || note_pos < note_cnt) && now >= end_ms) begin
                    spk_on = 1'b0;
                    if (note_pos < NOTE_SLOTS + 1) begin
                        note_pos++;
                    end
                    if (note_pos < note_cnt && note_pos < NOTE_SLOTS) begin
                        e = note_q[note_pos];
                        if (e[31:16] != '0) begin
                            tone_on(e[31:16]);
                        end
                        end_ms = now + e[15:0];
                    end
                end
            end
            FUNC_TONE: begin
                tone_on(hz);
            end
            FUNC_STOP: begin
                spk_on = 1'b0;
            end
            FUNC_TIMED: begin
                note_cnt = 0;
                note_pos = 0;
                tone_on(hz);
                end_ms = now + len;
            end
            FUNC_MELODY: begin
                chime_span(id, first, cnt);
                if (cnt > NOTE_SLOTS) begin
                    cnt = NOTE_SLOTS;
                end
                for (int i = 0; i < cnt; i++) begin
                    note_q[i] = chime_note(first + i);
                end
                note_cnt = cnt;
                note_pos = 0;
                if (cnt > 0) begin
                    tone_on(note_q[0][31:16]);
                    end_ms = now + note_q[0][15:0];
                end
            end
            default: begin
            end
        endcase
        r.spk    = spk_on;
        r.div    = div_q;
        r.loaded = div_fresh;
        r.busy   = spk_on || (note_pos < note_cnt);
        return r;
    endfunction

    function automatic int pick_idle(input bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [TONE_W-1:0] rand_hz();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            return '0;
        end else if (r < 20) begin
            return 16'd1;
        end else if (r < 30) begin
            return '1;
        end else if (r < 50) begin
            return TONE_W'($urandom_range(1, 50));
        end
        return TONE_W'($urandom);
    endfunction

    function automatic logic [LEN_W-1:0] rand_len();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            return '0;
        end else if (r < 20) begin
            return '1;
        end
        return LEN_W'($urandom_range(1, 400));
    endfunction

    function automatic void advance_clock();
        int r;
        r = $urandom_range(99);
        if (r < 3) begin
            ms_clock = $urandom;
        end else if (r < 5) begin
            ms_clock = 32'hFFFF_FF00 + $urandom_range(0, 255);
        end else if (r < 15) begin
            ms_clock = ms_clock;
        end else if (r < 25) begin
            ms_clock = ms_clock + $urandom_range(0, 70000);
        end else begin
            ms_clock = ms_clock + $urandom_range(20, 160);
        end
    endfunction

    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [TONE_W-1:0] hz,
                            input logic [LEN_W-1:0] len, input logic [ID_W-1:0] id,
                            input logic [TIME_W-1:0] now, input logic fixed = 1'b0,
                            input tone_result_t want = '0);
        int           gap;
        tone_result_t got;
        gap = pick_idle(tx_calm);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid     = 1'b1;
        i_func      = f;
        i_tone_hz   = hz;
        i_length_ms = len;
        i_preset_id = id;
        i_now       = now;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        moved_items++;
        got = tone_predict(f, hz, len, id, now);
        tone_expect_q.push_back(fixed ? want : got);
        if ($urandom_range(49) == 0) begin
            tx_calm = !tx_calm;
        end
    endtask

    task automatic send_tick();
        advance_clock();
        send_cmd(FUNC_TICK, TONE_W'($urandom), LEN_W'($urandom), ID_W'($urandom), ms_clock);
    endtask

    // hold the sender until every result is back and the block has settled
    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (tone_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base_clock(input logic [BASE_W-1:0] v);
        settle();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        base_hz    = v;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // receiver: random stalls, with calm stretches
    always @(negedge i_clk) begin
        if (rx_left > 0) begin
            i_stall = 1'b1;
            rx_left--;
        end else begin
            i_stall = 1'b0;
            if ($urandom_range(3) == 0) begin
                rx_left = pick_idle(rx_calm);
            end
        end
        if ($urandom_range(99) == 0) begin
            rx_calm = !rx_calm;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (tone_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("%0t: unexpected result spk %0b div %0d ld %0b busy %0b", $time,
                             o_speaker_on, o_divisor, o_divisor_loaded, o_busy_res);
                end
            end else begin
                head_r = tone_expect_q.pop_front();
                if (o_speaker_on !== head_r.spk || o_divisor !== head_r.div ||
                    o_divisor_loaded !== head_r.loaded || o_busy_res !== head_r.busy) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: mismatch exp spk %0b div %0d ld %0b busy %0b", $time,
                                 head_r.spk, head_r.div, head_r.loaded, head_r.busy);
                        $display("%0t:          got spk %0b div %0d ld %0b busy %0b", $time,
                                 o_speaker_on, o_divisor, o_divisor_loaded, o_busy_res);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL tone_melody_sequencer");
                $finish;
            end
        end
    end

    initial begin
        dir_row_t dir_tab [DIR_ROWS];
        dir_row_t row;
        int       stop_at;
        int       r;
        int       n;
        logic [BASE_W-1:0] base_val;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_func       = FUNC_TICK;
        i_tone_hz    = '0;
        i_length_ms  = '0;
        i_preset_id  = PRESET_BOOT;
        i_now        = '0;
        mismatches   = 0;
        moved_items  = 0;
        quiet_cycles = 0;
        rx_left      = 0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        ms_clock     = '0;
        base_hz      = BASE_CLOCK_RESET;
        note_cnt     = 0;
        note_pos     = 0;
        end_ms       = '0;
        spk_on       = 1'b0;
        div_q        = '0;
        div_fresh    = 1'b0;
        for (int i = 0; i < NOTE_SLOTS; i++) begin
            note_q[i] = '0;
        end

        // idle after reset, unused codes, stop, divisor extremes at the reset base clock
        dir_tab[0]  = '{FUNC_TICK, 16'd0, 16'd0, PRESET_BOOT, 32'd0, 1'b1, '0};
        dir_tab[1]  = '{FUNC_UNUSED_FIRST, 16'hFFFF, 16'hFFFF, PRESET_NOTIFY, 32'hFFFF_FFFF,
                        1'b1, '0};
        dir_tab[2]  = '{FUNC_UNUSED_MID, 16'h5A5A, 16'hA5A5, PRESET_ERROR, 32'h1234_5678,
                        1'b1, '0};
        dir_tab[3]  = '{FUNC_UNUSED_LAST, 16'd0, 16'd0, PRESET_BOOT, 32'd0, 1'b1, '0};
        dir_tab[4]  = '{FUNC_STOP, 16'd0, 16'd0, PRESET_BOOT, 32'd0, 1'b1, '0};
        dir_tab[5]  = '{FUNC_TONE, 16'hFFFF, 16'd0, PRESET_BOOT, 32'd0, 1'b1,
                        '{1'b1, 16'd18, 1'b1, 1'b1}};
        dir_tab[6]  = '{FUNC_TONE, 16'd1, 16'd0, PRESET_BOOT, 32'd0, 1'b0, '0};
        dir_tab[7]  = '{FUNC_TONE, 16'd0, 16'd0, PRESET_BOOT, 32'd0, 1'b0, '0};
        // timed tone whose end time wraps past zero
        dir_tab[8]  = '{FUNC_TIMED, 16'd1000, 16'hFFFF, PRESET_BOOT, 32'hFFFF_FFFF, 1'b0, '0};
        dir_tab[9]  = '{FUNC_TICK, 16'd0, 16'd0, PRESET_BOOT, 32'd0, 1'b0, '0};
        dir_tab[10] = '{FUNC_TICK, 16'd0, 16'd0, PRESET_BOOT, 32'd65534, 1'b0, '0};
        dir_tab[11] = '{FUNC_TICK, 16'd0, 16'd0, PRESET_BOOT, 32'd70000, 1'b0, '0};
        dir_tab[12] = '{FUNC_TIMED, 16'd0, 16'd5, PRESET_BOOT, 32'd100, 1'b0, '0};
        // boot chime, interrupted by a silent continuous tone that keeps its place
        dir_tab[13] = '{FUNC_MELODY, 16'd0, 16'd0, PRESET_BOOT, 32'd1000, 1'b0, '0};
        dir_tab[14] = '{FUNC_TICK, 16'd0, 16'd0, PRESET_BOOT, 32'd1119, 1'b0, '0};
        dir_tab[15] = '{FUNC_TICK, 16'd0, 16'd0, PRESET_BOOT, 32'd1120, 1'b0, '0};
        dir_tab[16] = '{FUNC_TONE, 16'd0, 16'd0, PRESET_BOOT, 32'd1130, 1'b0, '0};
        dir_tab[17] = '{FUNC_TICK, 16'd0, 16'd0, PRESET_BOOT, 32'd1240, 1'b0, '0};
        dir_tab[18] = '{FUNC_TICK, 16'd0, 16'd0, PRESET_BOOT, 32'd1360, 1'b0, '0};
        dir_tab[19] = '{FUNC_TICK, 16'd0, 16'd0, PRESET_BOOT, 32'd1560, 1'b0, '0};
        dir_tab[20] = '{FUNC_MELODY, 16'd0, 16'd0, PRESET_ERROR, 32'd0, 1'b0, '0};
        dir_tab[21] = '{FUNC_MELODY, 16'd0, 16'd0, PRESET_WINDOW, 32'hFFFF_FFF0, 1'b0, '0};
        dir_tab[22] = '{FUNC_TICK, 16'd0, 16'd0, PRESET_BOOT, 32'h0000_002C, 1'b0, '0};
        dir_tab[23] = '{FUNC_MELODY, 16'd0, 16'd0, PRESET_NOTIFY, 32'd5, 1'b0, '0};
        dir_tab[24] = '{FUNC_TICK, 16'd0, 16'd0, PRESET_BOOT, 32'd105, 1'b0, '0};

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_tab[i];
            send_cmd(row.func, row.hz, row.len, row.id, row.now, row.fixed, row.want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       base_val = BASE_CLOCK_RESET;
                1:       base_val = 24'd1;
                2:       base_val = '1;
                3:       base_val = BASE_W'($urandom_range(2, 2000));
                4:       base_val = BASE_W'($urandom_range(65536, 24'hFFFFFF));
                5:       base_val = BASE_W'($urandom_range(1, 24'hFFFFFF));
                6:       base_val = BASE_W'($urandom_range(1, 70000));
                default: base_val = BASE_CLOCK_RESET;
            endcase
            write_base_clock(base_val);
            stop_at = moved_items + ITEMS / PHASES;
            while (moved_items < stop_at) begin
                r = $urandom_range(99);
                if (r < 40) begin
                    // melody played through, with a tone or stop dropped in now and then
                    advance_clock();
                    send_cmd(FUNC_MELODY, TONE_W'($urandom), LEN_W'($urandom),
                             ID_W'($urandom), ms_clock);
                    n = $urandom_range(1, 14);
                    repeat (n) begin
                        if ($urandom_range(99) < 12) begin
                            send_cmd($urandom_range(1) ? FUNC_TONE : FUNC_STOP, rand_hz(),
                                     LEN_W'($urandom), ID_W'($urandom), ms_clock);
                        end else begin
                            send_tick();
                        end
                    end
                end else if (r < 60) begin
                    advance_clock();
                    send_cmd(FUNC_TIMED, rand_hz(), rand_len(), ID_W'($urandom), ms_clock);
                    n = $urandom_range(1, 5);
                    repeat (n) send_tick();
                end else if (r < 75) begin
                    // continuous tones ended by ticks push the note index to saturation
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        send_cmd(FUNC_TONE, rand_hz(), LEN_W'($urandom), ID_W'($urandom),
                                 ms_clock);
                        send_tick();
                    end
                end else begin
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        send_cmd(FUNC_W'($urandom_range(FUNC_UNUSED_LAST)), TONE_W'($urandom),
                                 LEN_W'($urandom), ID_W'($urandom), $urandom);
                    end
                end
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("PASS tone_melody_sequencer");
        end else begin
            $display("FAIL tone_melody_sequencer");
        end
        $finish;
    end

endmodule
